/* design/clipped_line_rasterizer_top_defines.svh */
// Assertion macros used by the port-level checker of the line rasterizer.
`ifndef CLIPPED_LINE_RASTERIZER_TOP_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_TOP_DEFINES_SVH

// Property checked only while the block is out of reset.
`define CLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/clr_pkg.sv */
// Shared constants, types and helper functions of the line rasterizer.
package clr_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int SCREEN_W       = 12;
  localparam int COLOR_W        = 16;
  localparam int CFG_IDX_W      = 4;
  // Wide enough for any coordinate (up to 16 bits) and a screen limit, signed.
  localparam int CMP_W          = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = SCREEN_W'(800);
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = SCREEN_W'(480);

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Drawing kinds.
  localparam logic [1:0] KIND_HSPAN  = 2'd0;
  localparam logic [1:0] KIND_VSPAN  = 2'd1;
  localparam logic [1:0] KIND_WALK_X = 2'd2;
  localparam logic [1:0] KIND_WALK_Y = 2'd3;

  // Line control state passed between the setup, step and state registers.
  typedef struct packed {
    logic [1:0] kind;
    logic       neg_x;
    logic       neg_y;
    logic       active;
  } ctl_t;

  // Per-pixel flags of a result transaction.
  typedef struct packed {
    logic visible;
    logic last;
    logic idle;
  } flags_t;

  // True when the point lies inside the configured screen.
  function automatic logic on_screen(input logic signed [CMP_W-1:0] x,
                                     input logic signed [CMP_W-1:0] y,
                                     input logic [SCREEN_W-1:0]     w,
                                     input logic [SCREEN_W-1:0]     h);
    logic signed [CMP_W-1:0] ws;
    logic signed [CMP_W-1:0] hs;
    ws = signed'(CMP_W'(w));
    hs = signed'(CMP_W'(h));
    return !x[CMP_W-1] && !y[CMP_W-1] && (x < ws) && (y < hs);
  endfunction

endpackage

/* design/clr_ifs.sv */
// Handshake interfaces for the item, pixel and configuration channels.
interface clr_item_if #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) ();
  import clr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_W-1:0]           line_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

interface clr_pixel_if #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) ();
  import clr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         visible;
  logic                         last;
  logic                         idle;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, idle,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last, idle,
                  output ready);
endinterface

interface clr_cfg_if ();
  import clr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCREEN_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/clr_setup.sv */
// Line setup: classifies a new line, clamps spans and prepares the error walk.
module clr_setup #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
  input  logic signed [COORD_BITS-1:0]   x_start_i,
  input  logic signed [COORD_BITS-1:0]   y_start_i,
  input  logic signed [COORD_BITS-1:0]   x_end_i,
  input  logic signed [COORD_BITS-1:0]   y_end_i,
  input  logic [clr_pkg::SCREEN_W-1:0]   screen_width_i,
  input  logic [clr_pkg::SCREEN_W-1:0]   screen_height_i,
  output logic signed [COORD_BITS-1:0]   cur_x_o,
  output logic signed [COORD_BITS-1:0]   cur_y_o,
  output logic signed [COORD_BITS-1:0]   stop_x_o,
  output logic signed [COORD_BITS-1:0]   stop_y_o,
  output logic [COORD_BITS:0]            error_acc_o,
  output logic [COORD_BITS-1:0]          major_delta_o,
  output logic [COORD_BITS-1:0]          minor_delta_o,
  output clr_pkg::ctl_t                  ctl_o,
  output logic signed [COORD_BITS-1:0]   pixel_x_o,
  output logic signed [COORD_BITS-1:0]   pixel_y_o,
  output clr_pkg::flags_t                flags_o
);
  import clr_pkg::*;

  logic signed [CMP_W-1:0] xs, ys, xe, ye;
  logic signed [CMP_W-1:0] lo, hi, lo_c, hi_c, fixed, lim, flim;
  logic signed [CMP_W-1:0] sx, sy, ex, ey;
  logic signed [CMP_W-1:0] dx, dy, major;
  logic                    horiz, vert, zero_len, span_off;

  assign xs = CMP_W'(x_start_i);
  assign ys = CMP_W'(y_start_i);
  assign xe = CMP_W'(x_end_i);
  assign ye = CMP_W'(y_end_i);

  assign zero_len = (xs == xe) && (ys == ye);
  assign horiz    = (ys == ye);
  assign vert     = (xs == xe);

  // Span bounds along the running axis, end pixel left out, then clamped.
  always_comb begin
    if (horiz) begin
      lo    = (xs > xe) ? xe + CMP_W'(1) : xs;
      hi    = (xs > xe) ? xs : xe - CMP_W'(1);
      fixed = ys;
      lim   = signed'(CMP_W'(screen_width_i));
      flim  = signed'(CMP_W'(screen_height_i));
    end else begin
      lo    = (ys > ye) ? ye + CMP_W'(1) : ys;
      hi    = (ys > ye) ? ys : ye - CMP_W'(1);
      fixed = xs;
      lim   = signed'(CMP_W'(screen_height_i));
      flim  = signed'(CMP_W'(screen_width_i));
    end
    lo_c     = lo[CMP_W-1] ? '0 : lo;
    hi_c     = (hi > lim - CMP_W'(1)) ? lim - CMP_W'(1) : hi;
    span_off = (lo_c > hi_c) || fixed[CMP_W-1] || (fixed >= flim);
    // Span pixel positions: first and last, laid along the running axis.
    sx = horiz ? lo_c : fixed;
    sy = horiz ? fixed : lo_c;
    ex = horiz ? hi_c : fixed;
    ey = horiz ? fixed : hi_c;
  end

  // Deltas of the error walk.
  assign dx    = (xe > xs) ? xe - xs : xs - xe;
  assign dy    = (ye > ys) ? ye - ys : ys - ye;
  assign major = (dx >= dy) ? dx : dy;

  // Pick the new line state and its first pixel.
  always_comb begin
    cur_x_o       = x_start_i;
    cur_y_o       = y_start_i;
    stop_x_o      = x_end_i;
    stop_y_o      = y_end_i;
    error_acc_o   = '0;
    major_delta_o = COORD_BITS'(major);
    minor_delta_o = (dx >= dy) ? COORD_BITS'(dy) : COORD_BITS'(dx);
    ctl_o.kind    = KIND_HSPAN;
    ctl_o.neg_x   = !(xe > xs);
    ctl_o.neg_y   = !(ye > ys);
    ctl_o.active  = 1'b0;
    pixel_x_o     = x_start_i;
    pixel_y_o     = y_start_i;
    flags_o.idle  = 1'b0;
    flags_o.last  = 1'b1;
    flags_o.visible = 1'b0;
    if (zero_len) begin
      // Single pixel line.
      flags_o.visible = on_screen(xs, ys, screen_width_i, screen_height_i);
    end else if (horiz || vert) begin
      if (!span_off) begin
        ctl_o.kind      = horiz ? KIND_HSPAN : KIND_VSPAN;
        cur_x_o         = COORD_BITS'(sx);
        cur_y_o         = COORD_BITS'(sy);
        stop_x_o        = COORD_BITS'(ex);
        stop_y_o        = COORD_BITS'(ey);
        ctl_o.active    = (lo_c != hi_c);
        pixel_x_o       = COORD_BITS'(sx);
        pixel_y_o       = COORD_BITS'(sy);
        flags_o.last    = (lo_c == hi_c);
        flags_o.visible = on_screen(sx, sy, screen_width_i, screen_height_i);
      end
    end else begin
      // Error walk starts at half the major delta and includes both ends.
      ctl_o.kind      = (dx >= dy) ? KIND_WALK_X : KIND_WALK_Y;
      error_acc_o     = {1'b0, major_delta_o >> 1};
      ctl_o.active    = 1'b1;
      flags_o.last    = 1'b0;
      flags_o.visible = on_screen(xs, ys, screen_width_i, screen_height_i);
    end
  end

endmodule

/* design/clr_step.sv */
// Step unit: advances the active line by one pixel.
module clr_step #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
  input  logic signed [COORD_BITS-1:0]  cur_x_i,
  input  logic signed [COORD_BITS-1:0]  cur_y_i,
  input  logic signed [COORD_BITS-1:0]  stop_x_i,
  input  logic signed [COORD_BITS-1:0]  stop_y_i,
  input  logic [COORD_BITS:0]           error_acc_i,
  input  logic [COORD_BITS-1:0]         major_delta_i,
  input  logic [COORD_BITS-1:0]         minor_delta_i,
  input  clr_pkg::ctl_t                 ctl_i,
  input  logic [clr_pkg::COLOR_W-1:0]   held_color_i,
  input  logic [clr_pkg::SCREEN_W-1:0]  screen_width_i,
  input  logic [clr_pkg::SCREEN_W-1:0]  screen_height_i,
  output logic signed [COORD_BITS-1:0]  cur_x_o,
  output logic signed [COORD_BITS-1:0]  cur_y_o,
  output logic [COORD_BITS:0]           error_acc_o,
  output logic                          active_o,
  output logic [clr_pkg::COLOR_W-1:0]   pixel_color_o,
  output clr_pkg::flags_t               flags_o
);
  import clr_pkg::*;

  localparam logic [COORD_BITS-1:0] One = COORD_BITS'(1);

  logic signed [COORD_BITS-1:0] x_walk, y_walk;
  logic [COORD_BITS:0]          acc_sum, acc_red;
  logic                         acc_wrap, last;

  // Signed unit steps along each axis.
  assign x_walk = ctl_i.neg_x ? cur_x_i - One : cur_x_i + One;
  assign y_walk = ctl_i.neg_y ? cur_y_i - One : cur_y_i + One;

  // Error accumulate and wrap for the walk kinds.
  assign acc_sum  = error_acc_i + {1'b0, minor_delta_i};
  assign acc_wrap = (acc_sum >= {1'b0, major_delta_i});
  assign acc_red  = acc_wrap ? acc_sum - {1'b0, major_delta_i} : acc_sum;

  always_comb begin
    cur_x_o     = cur_x_i;
    cur_y_o     = cur_y_i;
    error_acc_o = error_acc_i;
    last        = 1'b0;
    case (ctl_i.kind)
      KIND_HSPAN: begin
        cur_x_o = cur_x_i + One;
        last    = (cur_x_o >= stop_x_i);
      end
      KIND_VSPAN: begin
        cur_y_o = cur_y_i + One;
        last    = (cur_y_o >= stop_y_i);
      end
      KIND_WALK_X: begin
        cur_x_o     = x_walk;
        cur_y_o     = acc_wrap ? y_walk : cur_y_i;
        error_acc_o = acc_red;
        last        = (x_walk == stop_x_i);
      end
      KIND_WALK_Y: begin
        cur_y_o     = y_walk;
        cur_x_o     = acc_wrap ? x_walk : cur_x_i;
        error_acc_o = acc_red;
        last        = (y_walk == stop_y_i);
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // A step with no line in progress reports idle with blank color and flags.
  always_comb begin
    if (ctl_i.active) begin
      active_o        = !last;
      pixel_color_o   = held_color_i;
      flags_o.idle    = 1'b0;
      flags_o.last    = last;
      flags_o.visible = on_screen(CMP_W'(cur_x_o), CMP_W'(cur_y_o),
                                  screen_width_i, screen_height_i);
    end else begin
      active_o        = 1'b0;
      pixel_color_o   = '0;
      flags_o.idle    = 1'b1;
      flags_o.last    = 1'b0;
      flags_o.visible = 1'b0;
    end
  end

endmodule

/* design/clipped_line_rasterizer_top.sv */
// Top level of the clipped line rasterizer: channels, state and pipeline registers.
//
// Each item (a line start or a step) yields exactly one pixel transaction. The block
// takes one item per clock while the pixel output is not stalled; an accepted item
// passes through the input register, then through the setup or step logic into
// the result register; the add and compare of the error walk sit in that logic and
// set the rate. Configuration writes are always ready and take effect on the
// next clock; screen registers reset to 800 by 480.
module clipped_line_rasterizer_top #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clr_item_if.sink     item_if,
  clr_pixel_if.source  pixel_if,
  clr_cfg_if.sink      cfg_if
);
  import clr_pkg::*;

  // Configuration registers.
  logic [SCREEN_W-1:0] screen_width_q, screen_height_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_if.data;
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                         in_valid_q;
  logic                         mode_q;
  logic signed [COORD_BITS-1:0] x_start_q, y_start_q, x_end_q, y_end_q;
  logic [COLOR_W-1:0]           line_color_q;
  logic                         out_valid_q;
  logic                         fire;

  assign fire          = in_valid_q && (!out_valid_q || pixel_if.ready);
  assign item_if.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_if.ready) begin
      in_valid_q <= item_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_if.valid && item_if.ready) begin
      mode_q       <= item_if.mode;
      x_start_q    <= item_if.x_start;
      y_start_q    <= item_if.y_start;
      x_end_q      <= item_if.x_end;
      y_end_q      <= item_if.y_end;
      line_color_q <= item_if.line_color;
    end
  end

  // Line state.
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic [COORD_BITS:0]          error_acc_q;
  logic [COORD_BITS-1:0]        major_delta_q, minor_delta_q;
  ctl_t                         ctl_q;
  logic [COLOR_W-1:0]           held_color_q;

  // Setup results.
  logic signed [COORD_BITS-1:0] su_cur_x, su_cur_y, su_stop_x, su_stop_y;
  logic [COORD_BITS:0]          su_error_acc;
  logic [COORD_BITS-1:0]        su_major, su_minor;
  ctl_t                         su_ctl;
  logic signed [COORD_BITS-1:0] su_pixel_x, su_pixel_y;
  flags_t                       su_flags;

  clr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start_i       (x_start_q),
    .y_start_i       (y_start_q),
    .x_end_i         (x_end_q),
    .y_end_i         (y_end_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .cur_x_o         (su_cur_x),
    .cur_y_o         (su_cur_y),
    .stop_x_o        (su_stop_x),
    .stop_y_o        (su_stop_y),
    .error_acc_o     (su_error_acc),
    .major_delta_o   (su_major),
    .minor_delta_o   (su_minor),
    .ctl_o           (su_ctl),
    .pixel_x_o       (su_pixel_x),
    .pixel_y_o       (su_pixel_y),
    .flags_o         (su_flags)
  );

  // Step results.
  logic signed [COORD_BITS-1:0] st_cur_x, st_cur_y;
  logic [COORD_BITS:0]          st_error_acc;
  logic                         st_active;
  logic [COLOR_W-1:0]           st_color;
  flags_t                       st_flags;

  clr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cur_x_i         (cur_x_q),
    .cur_y_i         (cur_y_q),
    .stop_x_i        (stop_x_q),
    .stop_y_i        (stop_y_q),
    .error_acc_i     (error_acc_q),
    .major_delta_i   (major_delta_q),
    .minor_delta_i   (minor_delta_q),
    .ctl_i           (ctl_q),
    .held_color_i    (held_color_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .cur_x_o         (st_cur_x),
    .cur_y_o         (st_cur_y),
    .error_acc_o     (st_error_acc),
    .active_o        (st_active),
    .pixel_color_o   (st_color),
    .flags_o         (st_flags)
  );

  // State update when an item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      stop_x_q      <= '0;
      stop_y_q      <= '0;
      error_acc_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      ctl_q         <= '0;
      held_color_q  <= '0;
    end else if (fire) begin
      if (mode_q == MODE_START) begin
        cur_x_q       <= su_cur_x;
        cur_y_q       <= su_cur_y;
        stop_x_q      <= su_stop_x;
        stop_y_q      <= su_stop_y;
        error_acc_q   <= su_error_acc;
        major_delta_q <= su_major;
        minor_delta_q <= su_minor;
        ctl_q         <= su_ctl;
        held_color_q  <= line_color_q;
      end else begin
        cur_x_q      <= st_cur_x;
        cur_y_q      <= st_cur_y;
        error_acc_q  <= st_error_acc;
        ctl_q.active <= st_active;
      end
    end
  end

  // Result register.
  logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic [COLOR_W-1:0]           pixel_color_q;
  flags_t                       flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (pixel_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (mode_q == MODE_START) begin
        pixel_x_q     <= su_pixel_x;
        pixel_y_q     <= su_pixel_y;
        pixel_color_q <= line_color_q;
        flags_q       <= su_flags;
      end else begin
        pixel_x_q     <= st_flags.idle ? '0 : st_cur_x;
        pixel_y_q     <= st_flags.idle ? '0 : st_cur_y;
        pixel_color_q <= st_color;
        flags_q       <= st_flags;
      end
    end
  end

  assign pixel_if.valid       = out_valid_q;
  assign pixel_if.pixel_x     = pixel_x_q;
  assign pixel_if.pixel_y     = pixel_y_q;
  assign pixel_if.pixel_color = pixel_color_q;
  assign pixel_if.visible     = flags_q.visible;
  assign pixel_if.last        = flags_q.last;
  assign pixel_if.idle        = flags_q.idle;

endmodule

/* design/clr_checker.sv */
// Port-level checker of the line rasterizer and its bind to the top level.
`include "clipped_line_rasterizer_top_defines.svh"

module clr_checker #(
  parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [COORD_BITS-1:0]  pixel_x_i,
  input logic signed [COORD_BITS-1:0]  pixel_y_i,
  input logic [clr_pkg::COLOR_W-1:0]   pixel_color_i,
  input logic                          visible_i,
  input logic                          last_i,
  input logic                          idle_i
);
  import clr_pkg::*;

  // Items accepted whose pixel has not been delivered yet.
  logic [1:0] pending_q, pending_d;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_fire && out_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // The block holds at most two items and never shows a pixel it was not asked for.
  `CLR_ASSERT(a_pending_bound, (pending_q != 2'd3) && (!out_valid_i || pending_q != 2'd0), "pixel count does not match accepted items")

  // An idle report carries no pixel.
  `CLR_ASSERT(a_idle_blank, (out_valid_i && idle_i) |-> (!visible_i && !last_i && pixel_x_i == '0 && pixel_y_i == '0 && pixel_color_i == '0), "idle transaction carries pixel data")

  // A stalled pixel stays put.
  `CLR_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i) && $stable(last_i)), "stalled pixel changed")

  // Nothing is offered on the clock after reset has been seen.
  `CLR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_i, "pixel valid after reset")

endmodule

bind clipped_line_rasterizer_top clr_checker #(
  .COORD_BITS (COORD_BITS)
) u_clr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_if.valid),
  .in_ready_i    (item_if.ready),
  .out_valid_i   (pixel_if.valid),
  .out_ready_i   (pixel_if.ready),
  .pixel_x_i     (pixel_if.pixel_x),
  .pixel_y_i     (pixel_if.pixel_y),
  .pixel_color_i (pixel_if.pixel_color),
  .visible_i     (pixel_if.visible),
  .last_i        (pixel_if.last),
  .idle_i        (pixel_if.idle)
);
